// ----- rtl/sdas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdas_pkg
// Shared types and constants for the scaled decimal add / subtract / compare
// block: coefficient and scale widths, result codes, and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sdas_pkg;

    localparam int COEF_W  = 128;
    localparam int HALF_W  = 64;
    localparam int SCALE_W = 8;
    localparam int MODE_W  = 2;
    localparam int ORD_W   = 2;

    // Operation codes; bit 1 set selects compare
    localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
    localparam int                MODE_CMP_BIT = 1;

    // Order codes, two-bit signed
    localparam logic [ORD_W-1:0] ORD_LT = 2'b11;
    localparam logic [ORD_W-1:0] ORD_EQ = 2'b00;
    localparam logic [ORD_W-1:0] ORD_GT = 2'b01;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture operands, set up alignment
        logic step;   // one multiply-by-ten step
        logic cmp;    // register magnitude order
        logic fin;    // form result into output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cnt_zero;  // alignment finished
    } t_sts;

endpackage

// ----- rtl/sdas_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdas channel interfaces
// Valid/ready channels for the operand beat and the result beat.
// ----------------------------------------------------------------------------
interface sdas_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic               a_neg;
    logic signed [7:0]  a_scale;
    logic [63:0]        a_coef_hi;
    logic [63:0]        a_coef_lo;
    logic               b_neg;
    logic signed [7:0]  b_scale;
    logic [63:0]        b_coef_hi;
    logic [63:0]        b_coef_lo;

    modport source (
        output valid, mode, a_neg, a_scale, a_coef_hi, a_coef_lo,
               b_neg, b_scale, b_coef_hi, b_coef_lo,
        input  ready
    );
    modport sink (
        input  valid, mode, a_neg, a_scale, a_coef_hi, a_coef_lo,
               b_neg, b_scale, b_coef_hi, b_coef_lo,
        output ready
    );
endinterface

interface sdas_out_if;
    logic               valid;
    logic               ready;
    logic               res_neg;
    logic signed [7:0]  res_scale;
    logic [63:0]        res_coef_hi;
    logic [63:0]        res_coef_lo;
    logic signed [1:0]  order;
    logic               wrapped;

    modport source (
        output valid, res_neg, res_scale, res_coef_hi, res_coef_lo, order, wrapped,
        input  ready
    );
    modport sink (
        input  valid, res_neg, res_scale, res_coef_hi, res_coef_lo, order, wrapped,
        output ready
    );
endinterface

// ----- rtl/scaled_decimal_add_sub_compare.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_decimal_add_sub_compare
// Sign-magnitude decimal add, subtract and compare with 128-bit coefficients
// and signed 8-bit scales. The lower-scale coefficient is brought to the
// larger scale by repeated multiply-by-ten before the add or compare.
//
//   channel  dir  beat contents
//   i_in     in   mode, a_neg/a_scale/a_coef_hi/a_coef_lo, b_* the same
//   o_res    out  res_neg, res_scale, res_coef_hi, res_coef_lo, order, wrapped
//
// An item is accepted, aligned one decade per step, its magnitude order is
// registered, then the result register is loaded; the shared multiply-by-ten
// unit does one alignment step per cycle. One item is in flight at a time;
// the next is accepted the cycle after the previous one has reached the
// result register, even if it waits there.
// A stalled result holds the datapath in its final state. Reset is
// synchronous, active low, and clears the sequencer and result valid.
// ----------------------------------------------------------------------------
module scaled_decimal_add_sub_compare (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdas_in_if.sink    i_in,
    sdas_out_if.source o_res
);
    import sdas_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sdas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    sdas_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_in.mode),
        .i_a_neg       (i_in.a_neg),
        .i_a_scale     (i_in.a_scale),
        .i_a_coef_hi   (i_in.a_coef_hi),
        .i_a_coef_lo   (i_in.a_coef_lo),
        .i_b_neg       (i_in.b_neg),
        .i_b_scale     (i_in.b_scale),
        .i_b_coef_hi   (i_in.b_coef_hi),
        .i_b_coef_lo   (i_in.b_coef_lo),
        .o_res_neg     (o_res.res_neg),
        .o_res_scale   (o_res.res_scale),
        .o_res_coef_hi (o_res.res_coef_hi),
        .o_res_coef_lo (o_res.res_coef_lo),
        .o_order       (o_res.order),
        .o_wrapped     (o_res.wrapped)
    );

endmodule

// ----- rtl/sdas_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdas_ctrl
// Sequencer: accept a beat, run the alignment loop, register the magnitude
// order, then load the result register once it is free.
// ----------------------------------------------------------------------------
module sdas_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sdas_pkg::t_cmd o_cmd,
    input  sdas_pkg::t_sts i_sts
);
    import sdas_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ALIGN = 4'b0010,
        S_CMP   = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ALIGN;
                end
            end
            S_ALIGN: begin
                if (i_sts.cnt_zero) begin
                    n_state = S_CMP;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result beat until taken
    always_comb begin
        if (o_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/sdas_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdas_dp
// Datapath: operand registers, the shared multiply-by-ten unit with its step
// counter, the magnitude comparator and the add/subtract into the result
// register.
// ----------------------------------------------------------------------------
module sdas_dp (
    input  logic                                i_clk,
    input  sdas_pkg::t_cmd                      i_cmd,
    output sdas_pkg::t_sts                      o_sts,
    input  logic [sdas_pkg::MODE_W-1:0]         i_mode,
    input  logic                                i_a_neg,
    input  logic signed [sdas_pkg::SCALE_W-1:0] i_a_scale,
    input  logic [sdas_pkg::HALF_W-1:0]         i_a_coef_hi,
    input  logic [sdas_pkg::HALF_W-1:0]         i_a_coef_lo,
    input  logic                                i_b_neg,
    input  logic signed [sdas_pkg::SCALE_W-1:0] i_b_scale,
    input  logic [sdas_pkg::HALF_W-1:0]         i_b_coef_hi,
    input  logic [sdas_pkg::HALF_W-1:0]         i_b_coef_lo,
    output logic                                o_res_neg,
    output logic signed [sdas_pkg::SCALE_W-1:0] o_res_scale,
    output logic [sdas_pkg::HALF_W-1:0]         o_res_coef_hi,
    output logic [sdas_pkg::HALF_W-1:0]         o_res_coef_lo,
    output logic signed [sdas_pkg::ORD_W-1:0]   o_order,
    output logic                                o_wrapped
);
    import sdas_pkg::*;

    // Operand and loop registers
    logic [MODE_W-1:0]  r_mode;
    logic               r_a_neg, r_b_neg, r_a_zero, r_b_zero;
    logic [SCALE_W-1:0] r_scale;
    logic [COEF_W-1:0]  r_a, r_b;
    logic [SCALE_W-1:0] r_cnt;
    logic               r_sel_a;
    logic               r_wrap;
    logic               r_gt, r_eq;

    // Result register
    logic               r_res_neg;
    logic [SCALE_W-1:0] r_res_scale;
    logic [COEF_W-1:0]  r_res;
    logic [ORD_W-1:0]   r_order;
    logic               r_res_wrap;

    logic [SCALE_W:0]   d_ab, d_ba;
    logic               a_lower;
    logic [COEF_W-1:0]  sel_coef;
    logic [COEF_W+3:0]  prod;
    logic               prod_wrap;

    logic               b_neg_eff, ea, eb;
    logic               same_sign, a_ge;
    logic [COEF_W-1:0]  op_x, op_y;
    logic [COEF_W:0]    arith;
    logic               n_res_neg, n_res_wrap;
    logic [COEF_W-1:0]  n_res;
    logic [ORD_W-1:0]   n_order, mag_ord;

    // Scale difference, sign-extended to nine bits
    assign d_ab    = {i_a_scale[SCALE_W-1], i_a_scale} - {i_b_scale[SCALE_W-1], i_b_scale};
    assign d_ba    = {i_b_scale[SCALE_W-1], i_b_scale} - {i_a_scale[SCALE_W-1], i_a_scale};
    assign a_lower = d_ab[SCALE_W];

    // Multiply by ten as x*8 + x*2; anything above bit 127 is a wrap
    assign sel_coef  = r_sel_a ? r_a : r_b;
    assign prod      = {1'b0, sel_coef, 3'b000} + {3'b000, sel_coef, 1'b0};
    assign prod_wrap = |prod[COEF_W+3:COEF_W];

    assign o_sts.cnt_zero = (r_cnt == '0);

    // Load operands and advance alignment
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_a_neg  <= i_a_neg;
            r_b_neg  <= i_b_neg;
            r_a      <= {i_a_coef_hi, i_a_coef_lo};
            r_b      <= {i_b_coef_hi, i_b_coef_lo};
            r_a_zero <= ({i_a_coef_hi, i_a_coef_lo} == '0);
            r_b_zero <= ({i_b_coef_hi, i_b_coef_lo} == '0);
            r_sel_a  <= a_lower;
            r_wrap   <= 1'b0;
            if (a_lower) begin
                r_cnt   <= d_ba[SCALE_W-1:0];
                r_scale <= i_b_scale;
            end else begin
                r_cnt   <= d_ab[SCALE_W-1:0];
                r_scale <= i_a_scale;
            end
        end else if (i_cmd.step) begin
            if (r_sel_a) begin
                r_a <= prod[COEF_W-1:0];
            end else begin
                r_b <= prod[COEF_W-1:0];
            end
            r_wrap <= r_wrap | prod_wrap;
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    // Register magnitude order of the aligned coefficients
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_gt <= (r_a > r_b);
            r_eq <= (r_a == r_b);
        end
    end

    // Form the result
    always_comb begin
        b_neg_eff = (r_mode == MODE_SUB && !r_b_zero) ? !r_b_neg : r_b_neg;
        same_sign = (r_a_neg == b_neg_eff);
        a_ge      = r_gt || r_eq;
        ea        = r_a_neg && !r_a_zero;
        eb        = r_b_neg && !r_b_zero;

        op_x = (same_sign || a_ge) ? r_a : r_b;
        op_y = (same_sign || a_ge) ? r_b : r_a;
        if (same_sign) begin
            arith = {1'b0, op_x} + {1'b0, op_y};
        end else begin
            arith = {1'b0, op_x} - {1'b0, op_y};
        end

        if (r_gt) begin
            mag_ord = ea ? ORD_LT : ORD_GT;
        end else if (r_eq) begin
            mag_ord = ORD_EQ;
        end else begin
            mag_ord = ea ? ORD_GT : ORD_LT;
        end

        if (r_mode[MODE_CMP_BIT]) begin
            n_res      = '0;
            n_res_neg  = 1'b0;
            n_res_wrap = r_wrap;
            if (ea && !eb) begin
                n_order = ORD_LT;
            end else if (!ea && eb) begin
                n_order = ORD_GT;
            end else begin
                n_order = mag_ord;
            end
        end else begin
            n_res   = arith[COEF_W-1:0];
            n_order = ORD_EQ;
            if (same_sign) begin
                n_res_neg  = r_a_neg;
                n_res_wrap = r_wrap | arith[COEF_W];
            end else begin
                n_res_neg  = (a_ge ? r_a_neg : b_neg_eff) && (arith[COEF_W-1:0] != '0);
                n_res_wrap = r_wrap;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_res_neg   <= n_res_neg;
            r_res_scale <= r_scale;
            r_res       <= n_res;
            r_order     <= n_order;
            r_res_wrap  <= n_res_wrap;
        end
    end

    assign o_res_neg     = r_res_neg;
    assign o_res_scale   = r_res_scale;
    assign o_res_coef_hi = r_res[COEF_W-1:HALF_W];
    assign o_res_coef_lo = r_res[HALF_W-1:0];
    assign o_order       = r_order;
    assign o_wrapped     = r_res_wrap;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for scaled_decimal_add_sub_compare. Operand beats go in
// with random gaps and the result channel stalls at random. Each accepted
// operand beat is scored by a local model of scale alignment, signed
// add/subtract and compare. Every result beat is checked field by field
// against the oldest score, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import sdas_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RST_CYCLES   = 12;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1250;
    localparam int BLOCK_ITEMS  = 50;
    localparam int HOLD_CYCLES  = 400;
    localparam int SCALE_MAX    = 127;
    localparam int SCALE_MIN    = -128;

    // Compare codes not named in the package; the top code also compares
    localparam logic [MODE_W-1:0] MODE_CMP       = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CMP_ALIAS = 2'd3;

    localparam logic [COEF_W-1:0] COEF_MAX = '1;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic                      a_neg;
        logic signed [SCALE_W-1:0] a_scale;
        logic [COEF_W-1:0]         a_coef;
        logic                      b_neg;
        logic signed [SCALE_W-1:0] b_scale;
        logic [COEF_W-1:0]         b_coef;
    } t_operands;

    typedef struct packed {
        logic                      neg;
        logic signed [SCALE_W-1:0] scale;
        logic [COEF_W-1:0]         coef;
        logic [ORD_W-1:0]          order;
        logic                      wrapped;
    } t_decimal_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sdas_in_if  in_ch();
    sdas_out_if res_ch();

    t_decimal_result pending_results[$];
    int unsigned     mismatches    = 0;
    int unsigned     results_seen  = 0;
    int unsigned     cycle_count   = 0;
    bit              idle_on       = 1'b1;
    int              hold_off_left = 0;
    int              rx_wait_left  = 0;

    scaled_decimal_add_sub_compare uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Result model
    // ------------------------------------------------------------------
    function automatic t_decimal_result decimal_result(input t_operands op);
        t_decimal_result   r;
        logic [COEF_W-1:0] ma;
        logic [COEF_W-1:0] mb;
        logic [COEF_W+3:0] prod;
        logic [COEF_W:0]   total;
        int                sa;
        int                sb;
        logic              ea;
        logic              eb;
        logic              bn;
        r  = '0;
        ma = op.a_coef;
        mb = op.b_coef;
        sa = $signed(op.a_scale);
        sb = $signed(op.b_scale);
        // raise the lower-scale coefficient one decade per step, mod 2^128
        while (sa < sb) begin
            prod      = ma * 10;
            r.wrapped = r.wrapped | (|prod[COEF_W+3:COEF_W]);
            ma        = prod[COEF_W-1:0];
            sa++;
        end
        while (sb < sa) begin
            prod      = mb * 10;
            r.wrapped = r.wrapped | (|prod[COEF_W+3:COEF_W]);
            mb        = prod[COEF_W-1:0];
            sb++;
        end
        r.scale = sa[SCALE_W-1:0];

        if (op.mode[MODE_CMP_BIT]) begin
            // a zero coefficient carries no sign here
            ea = op.a_neg && (op.a_coef != '0);
            eb = op.b_neg && (op.b_coef != '0);
            if (ea != eb)
                r.order = ea ? ORD_LT : ORD_GT;
            else if (ma == mb)
                r.order = ORD_EQ;
            else
                r.order = ((ma > mb) ^ ea) ? ORD_GT : ORD_LT;
        end else begin
            bn = op.b_neg;
            if (op.mode == MODE_SUB && op.b_coef != '0)
                bn = ~bn;
            if (op.a_neg == bn) begin
                // like signs: magnitudes add, sign kept even for zero
                total     = ma + mb;
                r.wrapped = r.wrapped | total[COEF_W];
                r.coef    = total[COEF_W-1:0];
                r.neg     = op.a_neg;
            end else if (ma >= mb) begin
                r.coef = ma - mb;
                r.neg  = op.a_neg && (r.coef != '0);
            end else begin
                r.coef = mb - ma;
                r.neg  = bn && (r.coef != '0);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic int draw_wait();
        return idle_on ? int'($urandom_range(15, 0)) : 0;
    endfunction

    function automatic int clamp_scale(input int s);
        return (s > SCALE_MAX) ? SCALE_MAX : ((s < SCALE_MIN) ? SCALE_MIN : s);
    endfunction

    function automatic t_operands operands(input logic [MODE_W-1:0] mode,
                                           input logic a_neg, input int a_sc,
                                           input logic [COEF_W-1:0] a_coef,
                                           input logic b_neg, input int b_sc,
                                           input logic [COEF_W-1:0] b_coef);
        t_operands op;
        op.mode    = mode;
        op.a_neg   = a_neg;
        op.a_scale = a_sc[SCALE_W-1:0];
        op.a_coef  = a_coef;
        op.b_neg   = b_neg;
        op.b_scale = b_sc[SCALE_W-1:0];
        op.b_coef  = b_coef;
        return op;
    endfunction

    function automatic logic [COEF_W-1:0] random_coef();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return COEF_W'($urandom_range(9, 1));
            2:       return COEF_W'($urandom);
            3:       return {64'd0, $urandom, $urandom};
            4, 5:    return {$urandom, $urandom, $urandom, $urandom};
            6:       return COEF_MAX - COEF_W'($urandom_range(15, 0));
            default: return COEF_W'(1) << $urandom_range(COEF_W - 1, 0);
        endcase
    endfunction

    function automatic int random_scale();
        if ($urandom_range(7, 0) == 0)
            return int'($urandom_range(255, 0)) + SCALE_MIN;
        return int'($urandom_range(20, 0)) - 10;
    endfunction

    task automatic report_mismatch(input string what, input logic [COEF_W-1:0] got,
                                   input logic [COEF_W-1:0] want);
        mismatches++;
        $display("[%0t] result %0d %s: got %0h want %0h",
                 $time, results_seen, what, got, want);
    endtask

    // Offer one operand beat after a random gap and hold it until taken
    task automatic send_operands(input t_operands op);
        int gap;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        {in_ch.mode, in_ch.a_neg, in_ch.a_scale, in_ch.a_coef_hi, in_ch.a_coef_lo,
         in_ch.b_neg, in_ch.b_scale, in_ch.b_coef_hi, in_ch.b_coef_lo} = op;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall, score and check
    // ------------------------------------------------------------------
    // ready drops for a long hold-off first, then for the per-beat wait
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            res_ch.ready = 1'b0;
            hold_off_left--;
        end else if (rx_wait_left > 0) begin
            res_ch.ready = 1'b0;
            rx_wait_left--;
        end else begin
            res_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_operands       taken;
        t_decimal_result want;
        // score every accepted operand beat
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            taken = {in_ch.mode, in_ch.a_neg, in_ch.a_scale, in_ch.a_coef_hi,
                     in_ch.a_coef_lo, in_ch.b_neg, in_ch.b_scale, in_ch.b_coef_hi,
                     in_ch.b_coef_lo};
            pending_results.push_back(decimal_result(taken));
        end
        // check every accepted result beat against the oldest score
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            rx_wait_left = draw_wait();
            if (pending_results.size() == 0) begin
                report_mismatch("beat with nothing pending", '0, '0);
            end else begin
                want = pending_results.pop_front();
                if (res_ch.res_neg !== want.neg)
                    report_mismatch("res_neg", COEF_W'(res_ch.res_neg),
                                    COEF_W'(want.neg));
                if (res_ch.res_scale !== want.scale)
                    report_mismatch("res_scale", COEF_W'(res_ch.res_scale),
                                    COEF_W'(want.scale));
                if ({res_ch.res_coef_hi, res_ch.res_coef_lo} !== want.coef)
                    report_mismatch("res_coef", {res_ch.res_coef_hi, res_ch.res_coef_lo},
                                    want.coef);
                if (res_ch.order !== want.order)
                    report_mismatch("order", COEF_W'(res_ch.order), COEF_W'(want.order));
                if (res_ch.wrapped !== want.wrapped)
                    report_mismatch("wrapped", COEF_W'(res_ch.wrapped),
                                    COEF_W'(want.wrapped));
            end
        end
    end

    // Guard against a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_add_sub_corners();
        // full-scale sum wraps; plain and signed zeros
        send_operands(operands(MODE_ADD, 1'b0, 0, COEF_MAX, 1'b0, 0, COEF_MAX));
        send_operands(operands(MODE_ADD, 1'b0, 0, '0, 1'b0, 0, '0));
        send_operands(operands(MODE_ADD, 1'b1, 3, '0, 1'b1, 3, '0));
        // exact cancel clears the sign
        send_operands(operands(MODE_SUB, 1'b1, 2, 5, 1'b1, 2, 5));
        // a zero subtrahend keeps its sign
        send_operands(operands(MODE_SUB, 1'b0, 0, 7, 1'b1, 0, '0));
        // flipped b joins a's sign; a aligned up one decade
        send_operands(operands(MODE_SUB, 1'b1, 0, 3, 1'b0, 1, 10));
        // unlike signs, larger a, then larger b
        send_operands(operands(MODE_ADD, 1'b0, 0, 3, 1'b1, 1, 25));
        send_operands(operands(MODE_ADD, 1'b0, 0, 2, 1'b1, 1, 25));
        // carry out of the top, borrow and carry across the half-words
        send_operands(operands(MODE_ADD, 1'b0, 0, 1, 1'b0, 0, COEF_MAX));
        send_operands(operands(MODE_SUB, 1'b0, 0, COEF_W'(1) << 64, 1'b0, 0, 1));
        send_operands(operands(MODE_ADD, 1'b1, 5, {64'd0, {64{1'b1}}}, 1'b1, 5, 1));
    endtask

    task automatic test_compare_corners();
        send_operands(operands(MODE_CMP, 1'b1, 0, '0, 1'b0, 0, '0));
        send_operands(operands(MODE_CMP, 1'b1, 0, 1, 1'b0, 0, '0));
        send_operands(operands(MODE_CMP, 1'b0, 0, '0, 1'b1, 0, 1));
        send_operands(operands(MODE_CMP, 1'b1, 0, 5, 1'b1, 0, 7));
        send_operands(operands(MODE_CMP_ALIAS, 1'b0, 1, 12, 1'b0, 0, 12));
        // alignment wraps a; wrapped values are what get ordered
        send_operands(operands(MODE_CMP, 1'b0, 0, COEF_MAX, 1'b0, 2, 1));
        send_operands(operands(MODE_CMP_ALIAS, 1'b1, 0, 5, 1'b1, 1, 50));
    endtask

    task automatic test_scale_extremes();
        // widest spread, with and without a nonzero coefficient to grow
        send_operands(operands(MODE_ADD, 1'b0, SCALE_MIN, 1, 1'b0, SCALE_MAX, 1));
        send_operands(operands(MODE_ADD, 1'b1, SCALE_MAX, 9, 1'b0, SCALE_MIN, '0));
        send_operands(operands(MODE_SUB, 1'b0, SCALE_MAX, COEF_MAX, 1'b0, -SCALE_MAX, 3));
        send_operands(operands(MODE_CMP, 1'b1, SCALE_MIN, 4, 1'b0, SCALE_MIN, 4));
        // ten to the 38th fits, the 39th does not
        send_operands(operands(MODE_ADD, 1'b0, 38, '0, 1'b0, 0, 1));
        send_operands(operands(MODE_ADD, 1'b0, 39, '0, 1'b0, 0, 1));
    endtask

    // Hold the result side off so the block fills and stalls operand beats
    task automatic test_backpressure();
        int i;
        idle_on = 1'b0;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        @(posedge i_clk);
        hold_off_left = HOLD_CYCLES;
        for (i = 0; i < 8; i++)
            send_operands(operands(MODE_W'($urandom_range(3, 0)), 1'($urandom_range(1, 0)),
                                   random_scale(), random_coef(),
                                   1'($urandom_range(1, 0)),
                                   random_scale(), random_coef()));
        idle_on = 1'b1;
    endtask

    task automatic test_random(input int n);
        t_operands op;
        int        i;
        int        shape;
        int        a_sc;
        int        b_sc;
        for (i = 0; i < n; i++) begin
            // switch idling per block so some stretches run flat out
            if (i % BLOCK_ITEMS == 0)
                idle_on = ($urandom_range(3, 0) != 0);
            op.mode   = MODE_W'($urandom_range(3, 0));
            op.a_neg  = 1'($urandom_range(1, 0));
            op.b_neg  = 1'($urandom_range(1, 0));
            op.a_coef = random_coef();
            op.b_coef = random_coef();
            a_sc      = random_scale();
            shape     = $urandom_range(19, 0);
            if (shape < 8) begin
                b_sc = a_sc;
            end else if (shape < 14) begin
                b_sc = clamp_scale(a_sc + int'($urandom_range(12, 0)) - 6);
            end else if (shape < 17) begin
                b_sc = clamp_scale(a_sc + int'($urandom_range(80, 0)) - 40);
            end else if (shape < 18) begin
                b_sc = int'($urandom_range(255, 0)) + SCALE_MIN;
            end else begin
                // same value written at a finer scale: equal order, exact cancel
                b_sc      = clamp_scale(a_sc + int'($urandom_range(5, 0)));
                op.b_coef = op.a_coef;
                repeat (b_sc - a_sc) op.b_coef = op.b_coef * 10;
            end
            op.a_scale = a_sc[SCALE_W-1:0];
            op.b_scale = b_sc[SCALE_W-1:0];
            send_operands(op);
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_ADD;
        in_ch.a_neg     = 1'b0;
        in_ch.a_scale   = '0;
        in_ch.a_coef_hi = '0;
        in_ch.a_coef_lo = '0;
        in_ch.b_neg     = 1'b0;
        in_ch.b_scale   = '0;
        in_ch.b_coef_hi = '0;
        in_ch.b_coef_lo = '0;
        res_ch.ready    = 1'b0;

        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_add_sub_corners();
        test_compare_corners();
        test_scale_extremes();
        test_backpressure();
        test_random(RANDOM_ITEMS);

        @(negedge i_clk);
        in_ch.valid = 1'b0;

        // drain, then give any stray beat time to show up
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
